// ===== design/fdes_pkg.sv =====
// Shared types and constants for the FAT directory entry search unit.
// No dependencies; imported by every module of the block.
`default_nettype none
package fdes_pkg;

   localparam int NAME_BASE_W = 64;
   localparam int NAME_EXT_W  = 24;
   localparam int CSR_DATA_W  = 64;

   localparam logic [NAME_BASE_W-1:0] NAME_BASE_RESET = 64'h2020_2020_2020_2020;
   localparam logic [NAME_EXT_W-1:0]  NAME_EXT_RESET  = 24'h20_2020;

   // configuration register indexes
   localparam logic CSR_NAME_BASE = 1'b0;
   localparam logic CSR_NAME_EXT  = 1'b1;

   // special first bytes and attribute bits
   localparam logic [7:0] BYTE_END_MARK = 8'h00;
   localparam logic [7:0] BYTE_DELETED  = 8'hE5;
   localparam logic [7:0] ATTR_LFN_MASK = 8'h0F;
   localparam logic [7:0] ATTR_VOLUME   = 8'h08;
   localparam logic [7:0] ATTR_DIR      = 8'h10;

   // byte positions inside a 32-byte entry
   localparam logic [4:0] POS_FIRST     = 5'd0;
   localparam logic [4:0] POS_NAME_END  = 5'd11;
   localparam logic [4:0] POS_ATTR      = 5'd11;
   localparam logic [4:0] POS_CLUS_HI_L = 5'd20;
   localparam logic [4:0] POS_CLUS_HI_H = 5'd21;
   localparam logic [4:0] POS_CLUS_LO_L = 5'd26;
   localparam logic [4:0] POS_CLUS_LO_H = 5'd27;
   localparam logic [4:0] POS_SIZE      = 5'd28;
   localparam logic [4:0] POS_LAST      = 5'd31;

   localparam logic [15:0] ORDINAL_MAX = 16'hFFFF;

   // entry marker codes
   localparam logic [1:0] MARK_NORMAL  = 2'd0;
   localparam logic [1:0] MARK_DELETED = 2'd1;
   localparam logic [1:0] MARK_SKIP    = 2'd2;

   localparam logic STATUS_FOUND     = 1'b0;
   localparam logic STATUS_NOT_FOUND = 1'b1;

   typedef struct packed {
      logic       valid;
      logic [7:0] dir_byte;
      logic       search_start;
      logic       data_end;
   } fdes_item_type;

endpackage
`default_nettype wire

// ===== design/fdes_in_stage.sv =====
// Input register of the directory search: holds one accepted word.
// Depends on fdes_pkg.
`default_nettype none
module fdes_in_stage
   import fdes_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire logic [7:0]    req_dir_byte,
   input  wire logic          req_search_start,
   input  wire logic          req_data_end,
   input  wire logic          take,
   output fdes_item_type      item
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       start_ff, last_ff;
   logic       accept;

   assign req_stall = valid_ff && !take;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff  <= req_dir_byte;
         start_ff <= req_search_start;
         last_ff  <= req_data_end;
      end
   end

   assign item = '{valid: valid_ff, dir_byte: byte_ff,
                   search_start: start_ff, data_end: last_ff};

endmodule
`default_nettype wire

// ===== design/fdes_core.sv =====
// Search state, per-byte compare and capture, and the result register.
// Depends on fdes_pkg.
`default_nettype none
module fdes_core
   import fdes_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [NAME_BASE_W-1:0] name_base,
   input  wire logic [NAME_EXT_W-1:0]  name_ext,
   input  wire fdes_item_type          item,
   output logic                        take,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic                        rsp_status,
   output logic [15:0]                 rsp_entry_ordinal,
   output logic [7:0]                  rsp_attributes,
   output logic                        rsp_is_directory,
   output logic [31:0]                 rsp_start_cluster,
   output logic [31:0]                 rsp_file_size
);

   logic [4:0]  pos_ff, pos_in;
   logic [15:0] ord_ff, ord_in;
   logic        eq_ff, eq_in;
   logic [1:0]  mark_ff, mark_in;
   logic [7:0]  attr_ff, attr_in;
   logic [31:0] clus_ff, clus_in;
   logic [31:0] size_ff, size_in;
   logic        done_ff, done_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        status_ff;
   logic [15:0] ordinal_ff;
   logic [7:0]  attributes_ff;
   logic        is_dir_ff;
   logic [31:0] cluster_ff;
   logic [31:0] fsize_ff;

   logic        hit;
   logic        hit_status;
   logic [15:0] hit_ordinal;
   logic [7:0]  hit_attr;
   logic [31:0] hit_clus;
   logic [31:0] hit_size;

   logic [7:0]  name_bytes [16];
   logic [7:0]  b;

   // the item moves on whenever the result slot is free
   assign take = item.valid && (!rsp_valid_ff || !rsp_stall);
   assign b    = item.dir_byte;

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         name_bytes[i] = 8'h00;
      end
      for (int i = 0; i < 8; i++) begin
         name_bytes[i] = name_base[8*i +: 8];
      end
      for (int i = 0; i < 3; i++) begin
         name_bytes[8+i] = name_ext[8*i +: 8];
      end
   end

   always_comb begin
      pos_in      = pos_ff;
      ord_in      = ord_ff;
      eq_in       = eq_ff;
      mark_in     = mark_ff;
      attr_in     = attr_ff;
      clus_in     = clus_ff;
      size_in     = size_ff;
      done_in     = done_ff;
      hit         = 1'b0;
      hit_status  = STATUS_NOT_FOUND;
      hit_ordinal = '0;
      hit_attr    = '0;
      hit_clus    = '0;
      hit_size    = '0;

      if (take) begin
         if (item.search_start) begin
            pos_in  = '0;
            ord_in  = '0;
            eq_in   = 1'b1;
            mark_in = MARK_NORMAL;
            attr_in = '0;
            clus_in = '0;
            size_in = '0;
            done_in = 1'b0;
         end

         if (!done_in) begin
            if (pos_in == POS_FIRST && b == BYTE_END_MARK) begin
               done_in = 1'b1;
               hit     = 1'b1;
            end else begin
               if (pos_in == POS_FIRST && b == BYTE_DELETED) begin
                  mark_in = MARK_DELETED;
               end
               if (pos_in < POS_NAME_END) begin
                  if (b != name_bytes[pos_in[3:0]]) begin
                     eq_in = 1'b0;
                  end
               end else if (pos_in == POS_ATTR) begin
                  attr_in = b;
                  if (mark_in == MARK_NORMAL &&
                      ((b & ATTR_LFN_MASK) == ATTR_LFN_MASK ||
                       (b & ATTR_VOLUME) != 8'h00)) begin
                     mark_in = MARK_SKIP;
                  end
               end else if (pos_in == POS_CLUS_HI_L) begin
                  clus_in[23:16] = b;
               end else if (pos_in == POS_CLUS_HI_H) begin
                  clus_in[31:24] = b;
               end else if (pos_in == POS_CLUS_LO_L) begin
                  clus_in[7:0] = b;
               end else if (pos_in == POS_CLUS_LO_H) begin
                  clus_in[15:8] = b;
               end else if (pos_in >= POS_SIZE) begin
                  size_in[8*pos_in[1:0] +: 8] = b;
               end

               if (pos_in == POS_LAST && mark_in == MARK_NORMAL && eq_in) begin
                  hit         = 1'b1;
                  hit_status  = STATUS_FOUND;
                  hit_ordinal = ord_in;
                  hit_attr    = attr_in;
                  hit_clus    = clus_in;
                  hit_size    = size_in;
                  done_in     = 1'b1;
               end else begin
                  if (pos_in == POS_LAST) begin
                     // close the entry and start the next one
                     if (ord_in != ORDINAL_MAX) begin
                        ord_in = ord_in + 16'd1;
                     end
                     pos_in  = '0;
                     eq_in   = 1'b1;
                     mark_in = MARK_NORMAL;
                     attr_in = '0;
                     clus_in = '0;
                     size_in = '0;
                  end else begin
                     pos_in = pos_in + 5'd1;
                  end
                  if (item.data_end) begin
                     done_in = 1'b1;
                     hit     = 1'b1;
                  end
               end
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (hit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         ord_ff       <= '0;
         eq_ff        <= 1'b1;
         mark_ff      <= MARK_NORMAL;
         attr_ff      <= '0;
         clus_ff      <= '0;
         size_ff      <= '0;
         done_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         ord_ff       <= ord_in;
         eq_ff        <= eq_in;
         mark_ff      <= mark_in;
         attr_ff      <= attr_in;
         clus_ff      <= clus_in;
         size_ff      <= size_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (hit) begin
         status_ff     <= hit_status;
         ordinal_ff    <= hit_ordinal;
         attributes_ff <= hit_attr;
         is_dir_ff     <= (hit_attr & ATTR_DIR) != 8'h00;
         cluster_ff    <= hit_clus;
         fsize_ff      <= hit_size;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_entry_ordinal = ordinal_ff;
   assign rsp_attributes    = attributes_ff;
   assign rsp_is_directory  = is_dir_ff;
   assign rsp_start_cluster = cluster_ff;
   assign rsp_file_size     = fsize_ff;

endmodule
`default_nettype wire

// ===== design/fat_directory_entry_search_unit.sv =====
// Top level of the FAT short-name directory search: name registers,
// input stage and search core. Depends on fdes_pkg, fdes_in_stage, fdes_core.
//
//   port group   direction  carries
//   req_*        in         one directory byte with start and end flags
//   rsp_*        out        found entry fields or not-found status
//   csr_*        in         writes to name_base (0) and name_ext (1)
//
// One byte a cycle while no result is stalled; a byte is accepted into the input
// register, and its result is registered in the result register.
// Latency is set by the input register and the result register.
// After reset the block ignores bytes until one arrives with search_start.
// A stalled result holds the core; the input register then fills and stalls req.
`default_nettype none
module fat_directory_entry_search_unit
   import fdes_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [7:0]            req_dir_byte,
   input  wire logic                  req_search_start,
   input  wire logic                  req_data_end,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_status,
   output logic [15:0]                rsp_entry_ordinal,
   output logic [7:0]                 rsp_attributes,
   output logic                       rsp_is_directory,
   output logic [31:0]                rsp_start_cluster,
   output logic [31:0]                rsp_file_size,
   input  wire logic                  csr_wen,
   input  wire logic                  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [NAME_BASE_W-1:0] name_base_ff;
   logic [NAME_EXT_W-1:0]  name_ext_ff;
   fdes_item_type          item;
   logic                   take;

   always_ff @(posedge clock) begin
      if (reset) begin
         name_base_ff <= NAME_BASE_RESET;
         name_ext_ff  <= NAME_EXT_RESET;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_NAME_BASE: name_base_ff <= csr_wdata[NAME_BASE_W-1:0];
            CSR_NAME_EXT:  name_ext_ff  <= csr_wdata[NAME_EXT_W-1:0];
            default:       name_base_ff <= name_base_ff;
         endcase
      end
   end

   fdes_in_stage u_in_stage (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_dir_byte     (req_dir_byte),
      .req_search_start (req_search_start),
      .req_data_end     (req_data_end),
      .take             (take),
      .item             (item)
   );

   fdes_core u_core (
      .clock             (clock),
      .reset             (reset),
      .name_base         (name_base_ff),
      .name_ext          (name_ext_ff),
      .item              (item),
      .take              (take),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_entry_ordinal (rsp_entry_ordinal),
      .rsp_attributes    (rsp_attributes),
      .rsp_is_directory  (rsp_is_directory),
      .rsp_start_cluster (rsp_start_cluster),
      .rsp_file_size     (rsp_file_size)
   );

endmodule
`default_nettype wire
